[rtl/efcu_pkg.sv]
// ----------------------------------------------------------------------------
// efcu_pkg
// Shared constants, tables and helpers of the fly camera update block.
// ----------------------------------------------------------------------------
package efcu_pkg;

   // CORDIC iteration count (at most 24) and pitch limit in whole degrees
   localparam int CORDIC_STEPS    = 16;
   localparam int PITCH_LIMIT_DEG = 89;
   localparam int CIDX_W          = $clog2(CORDIC_STEPS);

   // Fixed-point constants, degrees in Q.16
   localparam logic signed [26:0] DEG90   = 27'sd5898240;
   localparam logic signed [26:0] DEG180  = 27'sd11796480;
   localparam logic signed [29:0] FULL360 = 30'sd23592960;
   localparam logic signed [28:0] PITCH_LIM = 29'(PITCH_LIMIT_DEG * 65536);
   localparam logic signed [31:0] CGAIN   = 32'sd326016437;
   localparam logic signed [15:0] ONE14   = 16'sd16384;

   // Register indexes
   localparam logic [1:0] REG_MOVE_SPEED = 2'd0;
   localparam logic [1:0] REG_MOUSE_SENS = 2'd1;

   // Key codes
   localparam logic [2:0] KEY_FWD   = 3'd0;
   localparam logic [2:0] KEY_BACK  = 3'd1;
   localparam logic [2:0] KEY_LEFT  = 3'd2;
   localparam logic [2:0] KEY_RIGHT = 3'd3;
   localparam logic [2:0] KEY_UP    = 3'd4;
   localparam logic [2:0] KEY_DOWN  = 3'd5;

   // atan(2^-i) in degrees Q.16
   function automatic logic [21:0] atan_deg(input logic [4:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   // Round a Q.29 value half up to Q1.14 and clamp to +-1.0
   function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd16384) r = 64'sd16384;
      if (r < -64'sd16384) r = -64'sd16384;
      return 16'(r);
   endfunction

   // Saturate a sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
      logic signed [31:0] r;
      if (s > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (s < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = 32'(s);
      return r;
   endfunction

endpackage

[rtl/euler_fly_camera_update.sv]
// ----------------------------------------------------------------------------
// euler_fly_camera_update
// Fly camera state: eye position, yaw/pitch and the front/right/up basis.
//
// Usage: one transaction on req_* is a key event (req_func 0) that moves the
// eye by move_speed * delta_time along front, right or world vertical, or a
// mouse event (req_func 1) that turns yaw/pitch and rebuilds the basis.
// Every transaction gives one rsp_* transaction holding the state after it.
// csr_we writes move_speed (index 0) or mouse_sensitivity (index 1).
// Sequencing: a key event for front/right updates the eye one axis at a time, and
// up/down updates eye y alone; a mouse event runs the angle products, the yaw
// wrap steps, CORDIC for yaw then pitch and the basis products; one shared 33x33
// multiplier, one CORDIC stage and the yaw wrap adder serve all of these.
// req_ready is high only while the sequencer is idle; an event may be taken
// while the previous result still waits, since results sit in an output
// register. A stalled receiver holds the result and blocks the next one.
// Reset restores eye (0,0,60), yaw -90, pitch 0, the default basis and the
// default register values.
// ----------------------------------------------------------------------------
module euler_fly_camera_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [2:0]         req_key_code,
   input  logic [15:0]        req_delta_time,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_eye_x,
   output logic signed [31:0] rsp_eye_y,
   output logic signed [31:0] rsp_eye_z,
   output logic signed [15:0] rsp_front_x,
   output logic signed [15:0] rsp_front_y,
   output logic signed [15:0] rsp_front_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import efcu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_KEY_DT, S_KEY_SPD, S_KEY_ADD, S_VERT_MUL, S_VERT_ADD,
      S_MOUSE_X, S_MOUSE_Y, S_MOUSE_P, S_WRAP, S_CSET, S_CITER, S_BASIS, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [23:0] speed_ff;
   logic [15:0] sens_ff;

   // latched transaction
   logic [2:0]         key_ff;
   logic [15:0]        dt_ff;
   logic signed [15:0] ox_ff, oy_ff;

   // camera state
   logic signed [31:0] eye_ff   [3];
   logic signed [15:0] front_ff [3];
   logic signed [15:0] right_ff [3];
   logic signed [15:0] up_ff    [3];
   logic signed [25:0] yaw_ff;
   logic signed [23:0] pitch_ff;

   // sequencer working registers
   logic [1:0]          idx_ff;
   logic signed [29:0]  wrap_ff;
   logic                phase_ff, neg_ff;
   logic [CIDX_W-1:0]   cidx_ff;
   logic signed [31:0]  cx_ff, cyv_ff;
   logic signed [26:0]  cz_ff;
   logic signed [31:0]  cy_ff, sy_ff, cp_ff, sp_ff, fx_ff, fz_ff;
   logic signed [65:0]  acc_ff;
   logic [2:0]          bj_ff;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_in, prod_ff;

   // other combinational terms
   logic signed [15:0] vec_sel;
   logic               key_neg;
   logic signed [33:0] kd, ksum, vd, vsum;
   logic signed [29:0] dx_in;
   logic signed [28:0] dy_in, pitch_in;
   logic signed [26:0] ang, fold_z;
   logic               fold_neg;
   logic signed [31:0] cdx, cdy, cx_in, cyv_in;
   logic signed [26:0] cz_in, atan_v;
   logic               clast;
   logic signed [65:0] upy_sum;

   assign req_ready = (state_ff == S_IDLE);

   // select the vector component the key moves along
   always_comb begin
      vec_sel = (key_ff == KEY_FWD || key_ff == KEY_BACK) ? front_ff[idx_ff]
                                                          : right_ff[idx_ff];
      key_neg = (key_ff == KEY_BACK || key_ff == KEY_LEFT);
   end

   // feed the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_KEY_DT: begin
            mul_a = $signed({17'd0, dt_ff});
            mul_b = 33'(vec_sel);
         end
         S_KEY_SPD: begin
            mul_a = $signed({9'd0, speed_ff});
            mul_b = 33'($signed(prod_ff[31:0]));
         end
         S_VERT_MUL: begin
            mul_a = $signed({9'd0, speed_ff});
            mul_b = $signed({17'd0, dt_ff});
         end
         S_MOUSE_X: begin
            mul_a = 33'(ox_ff);
            mul_b = $signed({17'd0, sens_ff});
         end
         S_MOUSE_Y: begin
            mul_a = 33'(oy_ff);
            mul_b = $signed({17'd0, sens_ff});
         end
         S_BASIS: begin
            unique case (bj_ff)
               3'd0: begin mul_a = 33'(cy_ff);    mul_b = 33'(cp_ff); end
               3'd1: begin mul_a = 33'(sy_ff);    mul_b = 33'(cp_ff); end
               3'd2: begin mul_a = -33'(cy_ff);   mul_b = 33'(sp_ff); end
               3'd3: begin mul_a = -33'(sy_ff);   mul_b = 33'(sp_ff); end
               3'd4: begin mul_a = 33'(cy_ff);    mul_b = 33'(fx_ff); end
               3'd5: begin mul_a = 33'(sy_ff);    mul_b = 33'(fz_ff); end
               default: begin mul_a = '0;         mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // position updates, angle increments and CORDIC step
   always_comb begin
      kd   = 34'((prod_ff + 66'sd536870912) >>> 30);
      if (key_neg) kd = -kd;
      ksum = 34'(eye_ff[idx_ff]) + kd;

      vd   = 34'((prod_ff + 66'sd32768) >>> 16);
      if (key_ff == KEY_DOWN) vd = -vd;
      vsum = 34'(eye_ff[1]) + vd;

      dx_in = 30'((prod_ff + 66'sd8) >>> 4);
      dy_in = 29'((prod_ff + 66'sd8) >>> 4);
      pitch_in = 29'(pitch_ff) + dy_in;
      if (pitch_in > PITCH_LIM) pitch_in = PITCH_LIM;
      if (pitch_in < -PITCH_LIM) pitch_in = -PITCH_LIM;

      ang = phase_ff ? 27'(pitch_ff) : 27'(yaw_ff);
      fold_neg = 1'b0;
      fold_z   = ang;
      if (ang > DEG90) begin
         fold_z = DEG180 - ang;
         fold_neg = 1'b1;
      end else if (ang < -DEG90) begin
         fold_z = -DEG180 - ang;
         fold_neg = 1'b1;
      end

      cdx    = cyv_ff >>> cidx_ff;
      cdy    = cx_ff >>> cidx_ff;
      atan_v = 27'(atan_deg(5'(cidx_ff)));
      if (cz_ff >= 0) begin
         cx_in  = cx_ff - cdx;
         cyv_in = cyv_ff + cdy;
         cz_in  = cz_ff - atan_v;
      end else begin
         cx_in  = cx_ff + cdx;
         cyv_in = cyv_ff - cdy;
         cz_in  = cz_ff + atan_v;
      end
      clast = (cidx_ff == CIDX_W'(CORDIC_STEPS - 1));

      upy_sum = acc_ff + prod_ff;
   end

   // sequencer, state and output registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         rsp_valid   <= 1'b0;
         speed_ff    <= 24'd1310720;
         sens_ff     <= 16'd6554;
         eye_ff[0]   <= '0;
         eye_ff[1]   <= '0;
         eye_ff[2]   <= 32'sd3932160;
         yaw_ff      <= -26'sd5898240;
         pitch_ff    <= '0;
         front_ff[0] <= '0;   front_ff[1] <= '0;    front_ff[2] <= -ONE14;
         right_ff[0] <= ONE14; right_ff[1] <= '0;   right_ff[2] <= '0;
         up_ff[0]    <= '0;   up_ff[1]    <= ONE14; up_ff[2]    <= '0;
         idx_ff      <= '0;
         bj_ff       <= '0;
         cidx_ff     <= '0;
         phase_ff    <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == REG_MOVE_SPEED) speed_ff <= csr_wdata;
            else if (csr_index == REG_MOUSE_SENS) sens_ff <= csr_wdata[15:0];
         end

         // drop the result once taken, unless a new one replaces it
         if (rsp_valid && rsp_ready && state_ff != S_DONE) rsp_valid <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  key_ff   <= req_key_code;
                  dt_ff    <= req_delta_time;
                  ox_ff    <= req_offset_x;
                  oy_ff    <= req_offset_y;
                  idx_ff   <= '0;
                  if (req_func) state_ff <= S_MOUSE_X;
                  else if (req_key_code == KEY_UP || req_key_code == KEY_DOWN)
                     state_ff <= S_VERT_MUL;
                  else if (req_key_code <= KEY_RIGHT) state_ff <= S_KEY_DT;
                  else state_ff <= S_DONE;
               end
            end
            S_KEY_DT:   state_ff <= S_KEY_SPD;
            S_KEY_SPD:  state_ff <= S_KEY_ADD;
            S_KEY_ADD: begin
               eye_ff[idx_ff] <= sat32(ksum);
               idx_ff <= idx_ff + 2'd1;
               state_ff <= (idx_ff == 2'd2) ? S_DONE : S_KEY_DT;
            end
            S_VERT_MUL: state_ff <= S_VERT_ADD;
            S_VERT_ADD: begin
               eye_ff[1] <= sat32(vsum);
               state_ff  <= S_DONE;
            end
            S_MOUSE_X:  state_ff <= S_MOUSE_Y;
            S_MOUSE_Y: begin
               wrap_ff  <= 30'(yaw_ff) + dx_in + 30'(DEG180);
               state_ff <= S_MOUSE_P;
            end
            S_MOUSE_P: begin
               pitch_ff <= 24'(pitch_in);
               state_ff <= S_WRAP;
            end
            // reduce yaw modulo 360 one step at a time
            S_WRAP: begin
               if (wrap_ff < 0) wrap_ff <= wrap_ff + FULL360;
               else if (wrap_ff >= FULL360) wrap_ff <= wrap_ff - FULL360;
               else begin
                  yaw_ff   <= 26'(wrap_ff - 30'(DEG180));
                  phase_ff <= 1'b0;
                  state_ff <= S_CSET;
               end
            end
            // fold the angle into +-90 and seed the rotation
            S_CSET: begin
               cx_ff    <= CGAIN;
               cyv_ff   <= '0;
               cz_ff    <= fold_z;
               neg_ff   <= fold_neg;
               cidx_ff  <= '0;
               state_ff <= S_CITER;
            end
            S_CITER: begin
               cx_ff   <= cx_in;
               cyv_ff  <= cyv_in;
               cz_ff   <= cz_in;
               cidx_ff <= cidx_ff + CIDX_W'(1);
               if (clast) begin
                  if (!phase_ff) begin
                     cy_ff    <= neg_ff ? -cx_in : cx_in;
                     sy_ff    <= cyv_in;
                     phase_ff <= 1'b1;
                     state_ff <= S_CSET;
                  end else begin
                     cp_ff    <= neg_ff ? -cx_in : cx_in;
                     sp_ff    <= cyv_in;
                     bj_ff    <= '0;
                     state_ff <= S_BASIS;
                  end
               end
            end
            // issue product bj, consume product bj-1
            S_BASIS: begin
               bj_ff <= bj_ff + 3'd1;
               unique case (bj_ff)
                  3'd1: fx_ff    <= 32'(prod_ff >>> 29);
                  3'd2: fz_ff    <= 32'(prod_ff >>> 29);
                  3'd3: up_ff[0] <= to_q14(64'(prod_ff >>> 29));
                  3'd4: up_ff[2] <= to_q14(64'(prod_ff >>> 29));
                  3'd5: acc_ff   <= prod_ff;
                  3'd6: begin
                     up_ff[1]    <= to_q14(64'(upy_sum >>> 29));
                     front_ff[0] <= to_q14(64'(fx_ff));
                     front_ff[1] <= to_q14(64'(sp_ff));
                     front_ff[2] <= to_q14(64'(fz_ff));
                     right_ff[0] <= to_q14(-64'(sy_ff));
                     right_ff[1] <= '0;
                     right_ff[2] <= to_q14(64'(cy_ff));
                     state_ff    <= S_DONE;
                  end
                  default: ;
               endcase
            end
            // hold until the output register is free
            S_DONE: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid   <= 1'b1;
                  rsp_eye_x   <= eye_ff[0];
                  rsp_eye_y   <= eye_ff[1];
                  rsp_eye_z   <= eye_ff[2];
                  rsp_front_x <= front_ff[0];
                  rsp_front_y <= front_ff[1];
                  rsp_front_z <= front_ff[2];
                  rsp_right_x <= right_ff[0];
                  rsp_right_y <= right_ff[1];
                  rsp_right_z <= right_ff[2];
                  rsp_up_x    <= up_ff[0];
                  rsp_up_y    <= up_ff[1];
                  rsp_up_z    <= up_ff[2];
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_pitch_in_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= 24'(PITCH_LIM)) && (pitch_ff >= -24'(PITCH_LIM)))
      else $error("pitch outside clamp range");

   a_right_y_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_y == 16'sd0))
      else $error("right vector has a vertical component");

   a_yaw_in_range: assert property (@(posedge clock) disable iff (reset)
      (yaw_ff >= -26'(DEG180)) && (yaw_ff < 26'(DEG180)))
      else $error("yaw not wrapped");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished result not presented");
`endif

endmodule
